// File: design/cff_pkg.sv
// Shared constants and types for the coincidence field-of-view filter.
`timescale 1ns / 1ps
package cff_pkg;

	// Field widths
	localparam int COORD_WIDTH = 16;
	localparam int COUNT_WIDTH = 32;
	localparam int RADIUS_W    = 15;
	localparam int CODE_W      = 8;
	localparam int CLASS_W     = 2;

	// Shared multiplier: operands wide enough for |cross|, chord^2 and radius^2
	localparam int MUL_W  = (2 * COORD_WIDTH + 1 > 2 * RADIUS_W) ?
		2 * COORD_WIDTH + 1 : 2 * RADIUS_W;
	localparam int PROD_W = 2 * MUL_W;
	// Signed accumulator for the cross product and the squared chord length
	localparam int ACC_W  = 2 * COORD_WIDTH + 3;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1600);

	// Raw class codes
	localparam logic [CODE_W-1:0] CODE_TRUE_A  = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_TRUE_B  = CODE_W'(10);
	localparam logic [CODE_W-1:0] CODE_RANDOM  = CODE_W'(1);
	localparam logic [CODE_W-1:0] CODE_SCATTER = CODE_W'(2);

	// Normalized classes
	localparam logic [CLASS_W-1:0] CLS_TRUE    = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_RANDOM  = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_SCATTER = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_OTHER   = 2'd3;

	// Class counter bank slots: seen at even, rejected at odd entries
	localparam int BANK_DEPTH = 8;
	localparam logic [2:0] BK_TRUES_SEEN        = 3'd0;
	localparam logic [2:0] BK_TRUES_REJECTED    = 3'd1;
	localparam logic [2:0] BK_RANDOMS_SEEN      = 3'd2;
	localparam logic [2:0] BK_RANDOMS_REJECTED  = 3'd3;
	localparam logic [2:0] BK_SCATTERS_SEEN     = 3'd4;
	localparam logic [2:0] BK_SCATTERS_REJECTED = 3'd5;
	localparam logic [2:0] BK_OTHERS_SEEN       = 3'd6;
	localparam logic [2:0] BK_OTHERS_REJECTED   = 3'd7;

	// Multiplier schedule, one product per step
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_XY = 3'd0;  // x1 * y2
	localparam logic [STEP_W-1:0] STEP_YX = 3'd1;  // x2 * y1
	localparam logic [STEP_W-1:0] STEP_DX = 3'd2;  // dx * dx
	localparam logic [STEP_W-1:0] STEP_RR = 3'd3;  // radius * radius
	localparam logic [STEP_W-1:0] STEP_DY = 3'd4;  // dy * dy
	localparam logic [STEP_W-1:0] STEP_CC = 3'd5;  // cross * cross
	localparam logic [STEP_W-1:0] STEP_RC = 3'd6;  // radius^2 * chord^2

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} cff_state_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

// File: design/cff_in_if.sv
// Input channel: one coincidence event per beat.
`timescale 1ns / 1ps
interface cff_in_if;
	import cff_pkg::*;

	logic              valid;
	logic              ready;
	coord_t            hit1_x;
	coord_t            hit1_y;
	coord_t            hit2_x;
	coord_t            hit2_y;
	logic [CODE_W-1:0] class_code;

	modport source (output valid, hit1_x, hit1_y, hit2_x, hit2_y, class_code,
		input ready);
	modport sink (input valid, hit1_x, hit1_y, hit2_x, hit2_y, class_code,
		output ready);
endinterface

// File: design/cff_out_if.sv
// Output channel: filter decision and counter snapshot per beat.
`timescale 1ns / 1ps
interface cff_out_if;
	import cff_pkg::*;

	logic               valid;
	logic               ready;
	logic               accepted;
	logic [CLASS_W-1:0] event_class;
	count_t             events_total;
	count_t             rejected_total;
	count_t             trues_seen;
	count_t             trues_rejected;
	count_t             randoms_seen;
	count_t             randoms_rejected;
	count_t             scatters_seen;
	count_t             scatters_rejected;
	count_t             others_seen;
	count_t             others_rejected;

	modport source (output valid, accepted, event_class, events_total, rejected_total,
		trues_seen, trues_rejected, randoms_seen, randoms_rejected, scatters_seen,
		scatters_rejected, others_seen, others_rejected, input ready);
	modport sink (input valid, accepted, event_class, events_total, rejected_total,
		trues_seen, trues_rejected, randoms_seen, randoms_rejected, scatters_seen,
		scatters_rejected, others_seen, others_rejected, output ready);
endinterface

// File: design/coincidence_fov_filter.sv
// Field-of-view filter and saturating event counters for coincidence events.
// The seven products of each event pass one by one through a single 33x33 multiplier.
// The input is not ready again until the result has been loaded into the output.
// Reset: all counters clear to zero at once, the radius returns to 1600.
`timescale 1ns / 1ps
module coincidence_fov_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cff_pkg::RADIUS_W-1:0]  cfg_wdata,
	cff_in_if.sink                        in_ch,
	cff_out_if.source                     out_ch
);
	import cff_pkg::*;

	cff_state_t st_q, st_d;
	logic [STEP_W-1:0] step_q;
	logic in_ready, in_fire, calc_en, done_en;

	logic [RADIUS_W-1:0] radius_q;
	coord_t x1_q, y1_q, x2_q, y2_q;
	logic [CLASS_W-1:0] cls_q;

	logic [MUL_W-1:0] op_a, op_b;
	logic op_neg;
	logic [PROD_W-1:0] prod_d, prod_q;
	logic neg_q;
	logic signed [ACC_W-1:0] acc_q, pmag, sprod;
	logic [ACC_W-1:0] acc_mag;
	logic [MUL_W-1:0] cross_q, r2_q;
	logic [PROD_W-1:0] lhs_q;
	logic signed [COORD_WIDTH:0] dx_s, dy_s;
	logic reject;

	logic out_valid_q, accepted_q;
	logic [CLASS_W-1:0] out_cls_q;
	count_t events_q, rejects_q;
	count_t bank_q [BANK_DEPTH];

	// Magnitude of a sign-extended coordinate or difference, zero-extended
	function automatic logic [MUL_W-1:0] abs_w(input logic [COORD_WIDTH:0] v);
		logic [COORD_WIDTH:0] m;
		m = v[COORD_WIDTH] ? (~v + 1'b1) : v;
		return MUL_W'(m);
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [CLASS_W-1:0] decode_class(input logic [CODE_W-1:0] c);
		logic [CLASS_W-1:0] k;
		if (c == CODE_TRUE_A || c == CODE_TRUE_B) begin
			k = CLS_TRUE;
		end else if (c == CODE_RANDOM) begin
			k = CLS_RANDOM;
		end else if (c == CODE_SCATTER) begin
			k = CLS_SCATTER;
		end else begin
			k = CLS_OTHER;
		end
		return k;
	endfunction

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		calc_en  = 1'b0;
		done_en  = 1'b0;
		case (st_q)
			ST_IDLE: in_ready = 1'b1;
			ST_CALC: calc_en = 1'b1;
			ST_DONE: done_en = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	assign in_ch.ready = in_ready;
	assign in_fire = in_ch.valid && in_ready;

	// Sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_fire) st_d = ST_CALC;
			ST_CALC: if (step_q == STEP_RC) st_d = ST_DONE;
			ST_DONE: if (done_en) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= STEP_XY;
		end else begin
			st_q <= st_d;
			if (calc_en && step_q != STEP_RC) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= STEP_XY;
			end
		end
	end

	// Radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// Capture the event
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x1_q  <= in_ch.hit1_x;
			y1_q  <= in_ch.hit1_y;
			x2_q  <= in_ch.hit2_x;
			y2_q  <= in_ch.hit2_y;
			cls_q <= decode_class(in_ch.class_code);
		end
	end

	assign dx_s = {x1_q[COORD_WIDTH-1], x1_q} - {x2_q[COORD_WIDTH-1], x2_q};
	assign dy_s = {y1_q[COORD_WIDTH-1], y1_q} - {y2_q[COORD_WIDTH-1], y2_q};

	// Select multiplier operands for this step
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_neg = 1'b0;
		case (step_q)
			STEP_XY: begin
				op_a   = abs_w({x1_q[COORD_WIDTH-1], x1_q});
				op_b   = abs_w({y2_q[COORD_WIDTH-1], y2_q});
				op_neg = x1_q[COORD_WIDTH-1] ^ y2_q[COORD_WIDTH-1];
			end
			STEP_YX: begin
				op_a   = abs_w({x2_q[COORD_WIDTH-1], x2_q});
				op_b   = abs_w({y1_q[COORD_WIDTH-1], y1_q});
				op_neg = x2_q[COORD_WIDTH-1] ^ y1_q[COORD_WIDTH-1];
			end
			STEP_DX: begin
				op_a = abs_w(dx_s);
				op_b = abs_w(dx_s);
			end
			STEP_RR: begin
				op_a = MUL_W'(radius_q);
				op_b = MUL_W'(radius_q);
			end
			STEP_DY: begin
				op_a = abs_w(dy_s);
				op_b = abs_w(dy_s);
			end
			STEP_CC: begin
				op_a = cross_q;
				op_b = cross_q;
			end
			STEP_RC: begin
				op_a = r2_q;
				op_b = MUL_W'(unsigned'(acc_q));
			end
			default: ;
		endcase
	end

	assign prod_d = op_a * op_b;

	// Signed view of the last product, for the accumulator
	assign pmag    = signed'({1'b0, prod_q[ACC_W-2:0]});
	assign sprod   = neg_q ? -pmag : pmag;
	assign acc_mag = acc_q[ACC_W-1] ? unsigned'(-acc_q) : unsigned'(acc_q);

	// Multiply, then fold the previous product into the datapath
	always_ff @(posedge clk) begin
		if (calc_en) begin
			prod_q <= prod_d;
			neg_q  <= op_neg;
			case (step_q)
				STEP_YX: acc_q <= sprod;
				STEP_DX: acc_q <= acc_q - sprod;
				STEP_RR: begin
					cross_q <= MUL_W'(acc_mag);
					acc_q   <= sprod;
				end
				STEP_DY: r2_q <= prod_q[MUL_W-1:0];
				STEP_CC: acc_q <= acc_q + sprod;
				STEP_RC: lhs_q <= prod_q;
				default: ;
			endcase
		end
	end

	// cross^2 against radius^2 * chord^2
	assign reject = lhs_q > prod_q;

	// Counters and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			events_q    <= '0;
			rejects_q   <= '0;
			for (int i = 0; i < BANK_DEPTH; i++) begin
				bank_q[i] <= '0;
			end
		end else begin
			if (done_en) begin
				out_valid_q <= 1'b1;
				events_q    <= sat_inc(events_q);
				bank_q[{cls_q, 1'b0}] <= sat_inc(bank_q[{cls_q, 1'b0}]);
				if (reject) begin
					rejects_q <= sat_inc(rejects_q);
					bank_q[{cls_q, 1'b1}] <= sat_inc(bank_q[{cls_q, 1'b1}]);
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_en) begin
			accepted_q <= !reject;
			out_cls_q  <= cls_q;
		end
	end

	// Drive the result beat; counters hold until the next event finishes
	assign out_ch.valid             = out_valid_q;
	assign out_ch.accepted          = accepted_q;
	assign out_ch.event_class       = out_cls_q;
	assign out_ch.events_total      = events_q;
	assign out_ch.rejected_total    = rejects_q;
	assign out_ch.trues_seen        = bank_q[BK_TRUES_SEEN];
	assign out_ch.trues_rejected    = bank_q[BK_TRUES_REJECTED];
	assign out_ch.randoms_seen      = bank_q[BK_RANDOMS_SEEN];
	assign out_ch.randoms_rejected  = bank_q[BK_RANDOMS_REJECTED];
	assign out_ch.scatters_seen     = bank_q[BK_SCATTERS_SEEN];
	assign out_ch.scatters_rejected = bank_q[BK_SCATTERS_REJECTED];
	assign out_ch.others_seen       = bank_q[BK_OTHERS_SEEN];
	assign out_ch.others_rejected   = bank_q[BK_OTHERS_REJECTED];

endmodule

// File: design/cff_checker.sv
// Port-level checks for the coincidence field-of-view filter, bound to the top level.
`timescale 1ns / 1ps
module cff_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input cff_pkg::count_t events_total,
	input cff_pkg::count_t rejected_total
);
	import cff_pkg::*;

	// Hold a result beat until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// Go busy after taking an event
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted event");

	// Advance the event count by one with each new result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (events_total == $past(events_total) + 1'b1) ||
			(&events_total))
		else $error("event count did not advance with the result");

	// Never count more rejections than events
	a_rej_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rejected_total <= events_total)
		else $error("rejection count exceeds event count");

endmodule

bind coincidence_fov_filter cff_checker u_cff_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.events_total   (out_ch.events_total),
	.rejected_total (out_ch.rejected_total)
);
